// ===== hw/rtl/keypad_press_autorepeat_assert.svh =====
// assertion macros for the keypad autorepeat rtl
`ifndef KEYPAD_PRESS_AUTOREPEAT_ASSERT_SVH
`define KEYPAD_PRESS_AUTOREPEAT_ASSERT_SVH

// condition implies consequence in the same cycle
`define KPA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad autorepeat check failed");

// condition implies consequence in the next cycle
`define KPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad autorepeat check failed");

`endif

// ===== hw/rtl/kpa_pkg.sv =====
// types, constants and helper functions for the keypad autorepeat block
package kpa_pkg;

  localparam int NUM_KEYS    = 16;
  localparam int IDX_W       = $clog2(NUM_KEYS);
  localparam int KEY_FIELD_W = 16;
  localparam int QUERY_W     = 4;
  localparam int INDEX_W     = 4;
  localparam int AGE_W       = 5;
  localparam int DELAY_W     = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [AGE_W-1:0]   AGE_MAX          = 5'd31;
  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST  = 5'd20;
  localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = 5'd5;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_KEYS_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 2'd2;

  typedef logic [NUM_KEYS-1:0] keys_t;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] keys_held;
    logic                   wait_for_key;
    logic [QUERY_W-1:0]     query_key;
  } frame_t;

  typedef struct packed {
    logic                   key_caught;
    logic [INDEX_W-1:0]     key_index;
    logic                   query_held;
    logic [KEY_FIELD_W-1:0] held_mask;
  } result_t;

  typedef struct packed {
    logic               keys_enabled;
    logic [DELAY_W-1:0] first_delay;
    logic [DELAY_W-1:0] repeat_delay;
  } cfg_t;

  typedef struct packed {
    keys_t repeat_key;
  } status_t;

  // priority encoder, lowest set bit wins
  function automatic logic [IDX_W-1:0] lowest_index(keys_t v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/kpa_core.sv =====
// key state registers with the per-frame update, press detection and repeat catch
module kpa_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  kpa_pkg::frame_t  frame,
  input  kpa_pkg::cfg_t    cfg,
  output kpa_pkg::result_t result,
  output kpa_pkg::status_t status
);

  kpa_pkg::keys_t keys_now, keys_prev, keys_hidden, repeat_key;
  logic [kpa_pkg::AGE_W-1:0]   frame_age;
  logic [kpa_pkg::DELAY_W-1:0] hold_span;

  kpa_pkg::keys_t keys_now_next, keys_prev_next, keys_hidden_next, repeat_key_next;
  logic [kpa_pkg::AGE_W-1:0]   frame_age_next;
  logic [kpa_pkg::DELAY_W-1:0] hold_span_next;

  kpa_pkg::keys_t held, prev_upd, hidden_upd, repeat_upd, visible, visible_shift;
  kpa_pkg::keys_t prev_chk, press, fresh, pick, pick_low;
  logic [kpa_pkg::AGE_W-1:0] age_inc;
  logic catching, fire;

  // frame update: age, latch of the held bitmap, unhide changed keys
  always_comb begin
    age_inc = (frame_age == kpa_pkg::AGE_MAX) ? frame_age
                                              : kpa_pkg::AGE_W'(frame_age + 1'b1);
    held    = kpa_pkg::keys_t'(frame.keys_held);
    if (cfg.keys_enabled) begin
      prev_upd      = keys_now;
      keys_now_next = held;
      hidden_upd    = keys_hidden & ~(keys_now ^ held);
      repeat_upd    = repeat_key & hidden_upd;
    end else begin
      prev_upd      = keys_prev;
      keys_now_next = keys_now;
      hidden_upd    = keys_hidden;
      repeat_upd    = repeat_key;
    end
    visible       = keys_now_next & ~hidden_upd;
    visible_shift = visible >> frame.query_key;
  end

  // catch: re-arm the repeat key once its span is over, then pick a press
  always_comb begin
    catching = cfg.keys_enabled && frame.wait_for_key;
    prev_chk = (catching && (age_inc >= hold_span)) ? (prev_upd & ~repeat_upd) : prev_upd;
    press    = keys_now_next & ~prev_chk;
    fire     = catching && (|press);
    fresh    = press & ~repeat_upd;
    pick     = (|fresh) ? fresh : repeat_upd;
    pick_low = pick & kpa_pkg::keys_t'(~pick + 1'b1);

    keys_prev_next = prev_chk;
    if (fire) begin
      keys_hidden_next = hidden_upd | pick;
      repeat_key_next  = pick_low;
      frame_age_next   = '0;
      hold_span_next   = (pick != repeat_upd) ? cfg.first_delay : cfg.repeat_delay;
    end else begin
      keys_hidden_next = hidden_upd;
      repeat_key_next  = repeat_upd;
      frame_age_next   = age_inc;
      hold_span_next   = hold_span;
    end
  end

  // result of this frame
  always_comb begin
    result.key_caught = fire;
    result.key_index  = fire ? kpa_pkg::INDEX_W'(kpa_pkg::lowest_index(pick_low)) : '0;
    result.query_held = (int'(frame.query_key) < kpa_pkg::NUM_KEYS) ? visible_shift[0] : 1'b0;
    result.held_mask  = kpa_pkg::KEY_FIELD_W'(visible);
    status.repeat_key = repeat_key;
  end

  // state registers, advanced once per frame
  always_ff @(posedge clk) begin
    if (rst) begin
      keys_now    <= '0;
      keys_prev   <= '0;
      keys_hidden <= '0;
      repeat_key  <= '0;
      frame_age   <= kpa_pkg::AGE_MAX;
      hold_span   <= '0;
    end else if (step) begin
      keys_now    <= keys_now_next;
      keys_prev   <= keys_prev_next;
      keys_hidden <= keys_hidden_next;
      repeat_key  <= repeat_key_next;
      frame_age   <= frame_age_next;
      hold_span   <= hold_span_next;
    end
  end

endmodule

// ===== hw/rtl/keypad_press_autorepeat.sv =====
// keypad typematic autorepeat: frame register, core update and result register
// path: request in the frame register, then its result in the result register
// one frame per cycle unless result_stall; single-pass core between two registers
// the frame register takes a new request while a finished result still waits
// reset: key state cleared, frame age saturated, registers back to enabled, 20, 5
module keypad_press_autorepeat (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             frame_valid,
  output logic                             frame_stall,
  input  kpa_pkg::frame_t                  frame,
  output logic                             result_valid,
  input  logic                             result_stall,
  output kpa_pkg::result_t                 result,
  input  logic                             cfg_we,
  input  logic [kpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  `include "keypad_press_autorepeat_assert.svh"

  logic              hold_vld;
  kpa_pkg::frame_t   hold_frame;
  kpa_pkg::cfg_t     cfg;
  kpa_pkg::result_t  core_result;
  kpa_pkg::status_t  core_status;
  logic              advance;

  // frame moves into the core when the result register is free or draining
  assign advance     = hold_vld && (!result_valid || !result_stall);
  assign frame_stall = hold_vld && !advance;

  kpa_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .frame  (hold_frame),
    .cfg    (cfg),
    .result (core_result),
    .status (core_status)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keys_enabled <= 1'b1;
      cfg.first_delay  <= kpa_pkg::FIRST_DELAY_RST;
      cfg.repeat_delay <= kpa_pkg::REPEAT_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kpa_pkg::CFG_KEYS_ENABLED: cfg.keys_enabled <= cfg_data[0];
        kpa_pkg::CFG_FIRST_DELAY:  cfg.first_delay  <= cfg_data;
        kpa_pkg::CFG_REPEAT_DELAY: cfg.repeat_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (!frame_stall) begin
      hold_vld <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!frame_stall && frame_valid) begin
      hold_frame <= frame;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

  // checks
  `KPA_ASSERT_NEXT(a_req_taken, frame_valid && !frame_stall, hold_vld)
  `KPA_ASSERT_SAME(a_index_idle, result_valid && !result.key_caught, result.key_index == '0)
  `KPA_ASSERT_SAME(a_repeat_onehot, 1'b1, $onehot0(core_status.repeat_key))

endmodule
